[rtl/last_plugged_input_selector_macros.svh]
// assertion macros shared by the checker of the last-plugged input selector
// no dependencies; included by the checker file
`ifndef LAST_PLUGGED_INPUT_SELECTOR_MACROS_SVH
`define LAST_PLUGGED_INPUT_SELECTOR_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define LPIS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define LPIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lpis_pkg.sv]
// shared types and constants of the last-plugged input selector
// no dependencies; used by every other file of the block but the assertion macros
package lpis_pkg;

   localparam int PORT_W        = 4;
   localparam int CNT_OUT_W     = 4;
   localparam int DEF_NUM_PORTS = 8;

   localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 4'd1;

   typedef enum logic {
      CMD_PLUG   = 1'b0,
      CMD_UNPLUG = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EXEC = 1'b1
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic commit;
   } dp_ctrl_type;

endpackage

[rtl/lpis_req_if.sv]
// request channel of the selector: plug and unplug events
// depends on lpis_pkg
interface lpis_req_if;
   import lpis_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [PORT_W-1:0] port;

   modport source (output valid, cmd, port, input ready);
   modport sink   (input valid, cmd, port, output ready);
endinterface

[rtl/lpis_rsp_if.sv]
// response channel of the selector: selected port, entry count, status
// depends on lpis_pkg
interface lpis_rsp_if;
   import lpis_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PORT_W-1:0]    selected_port;
   logic [CNT_OUT_W-1:0] entry_count;
   logic [1:0]           status;

   modport source (output valid, selected_port, entry_count, status, input ready);
   modport sink   (input valid, selected_port, entry_count, status, output ready);
endinterface

[rtl/lpis_ctrl.sv]
// controller of the selector: sequences accept, execute and response hold
// depends on lpis_pkg
module lpis_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lpis_pkg::dp_ctrl_type dp_ctrl
);
   import lpis_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_EXEC;
         end
         CS_EXEC: begin
            if (slot_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      dp_ctrl.load   = 1'b0;
      dp_ctrl.commit = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_ready    = 1'b1;
            dp_ctrl.load = req_valid;
         end
         CS_EXEC: begin
            // output register may still hold an untaken result
            dp_ctrl.commit = slot_free;
         end
         default: ;
      endcase
      rsp_valid_in = dp_ctrl.commit || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/lpis_dp.sv]
// datapath of the selector: port list cells, count, default port, result register
// depends on lpis_pkg
module lpis_dp #(
   parameter int NUM_PORTS = lpis_pkg::DEF_NUM_PORTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lpis_pkg::dp_ctrl_type          dp_ctrl,
   input  logic                           in_cmd,
   input  logic [lpis_pkg::PORT_W-1:0]    in_port,
   input  logic                           csr_wr_en,
   input  logic [lpis_pkg::PORT_W-1:0]    csr_wr_data,
   output logic [lpis_pkg::PORT_W-1:0]    selected_port,
   output logic [lpis_pkg::CNT_OUT_W-1:0] entry_count,
   output logic [1:0]                     status
);
   import lpis_pkg::*;

   localparam int CW = $clog2(NUM_PORTS + 1);

   logic [PORT_W-1:0]    list_ff [NUM_PORTS];
   logic [PORT_W-1:0]    list_in [NUM_PORTS];
   logic [CW-1:0]        count_ff, count_in;
   logic                 cmd_ff;
   logic [PORT_W-1:0]    port_ff;
   logic [PORT_W-1:0]    default_ff;
   logic [PORT_W-1:0]    sel_ff, sel_in;
   logic [CNT_OUT_W-1:0] cnt_ff, cnt_in;
   status_type           status_ff, status_in;

   logic [NUM_PORTS-1:0] match, first, at_or_above;
   logic                 found, is_full, is_empty;
   logic [CW+3:0]        cnt_ext;

   always_comb begin
      // parallel compare against the valid cells, oldest match wins
      for (int i = 0; i < NUM_PORTS; i++) begin
         match[i] = (CW'(i) < count_ff) && (list_ff[i] == port_ff);
      end
      first = match & (~match + NUM_PORTS'(1));
      found = |match;
      at_or_above[0] = first[0];
      for (int i = 1; i < NUM_PORTS; i++) begin
         at_or_above[i] = at_or_above[i-1] | first[i];
      end
      is_full  = (count_ff == CW'(NUM_PORTS));
      is_empty = (count_ff == '0);

      list_in   = list_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      if (cmd_ff == CMD_PLUG) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else begin
            for (int i = 0; i < NUM_PORTS; i++) begin
               if (count_ff == CW'(i)) list_in[i] = port_ff;
            end
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else if (!found) begin
            status_in = ST_NOT_FOUND;
         end else begin
            // close the gap; cells past the count hold zero, so the vacated one clears
            for (int i = 0; i < NUM_PORTS - 1; i++) begin
               if (at_or_above[i]) list_in[i] = list_ff[i+1];
            end
            if (at_or_above[NUM_PORTS-1]) list_in[NUM_PORTS-1] = '0;
            count_in = count_ff - CW'(1);
         end
      end

      sel_in = default_ff;
      for (int i = 0; i < NUM_PORTS; i++) begin
         if (count_in == CW'(i + 1)) sel_in = list_in[i];
      end
      cnt_ext = (CW + 4)'(count_in);
      cnt_in  = cnt_ext[CNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PORTS; i++) list_ff[i] <= '0;
         count_ff   <= '0;
         default_ff <= DEFAULT_PORT_RST;
      end else begin
         if (dp_ctrl.commit) begin
            list_ff  <= list_in;
            count_ff <= count_in;
         end
         if (csr_wr_en) default_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_ctrl.load) begin
         cmd_ff  <= in_cmd;
         port_ff <= in_port;
      end
      if (dp_ctrl.commit) begin
         sel_ff    <= sel_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

   assign selected_port = sel_ff;
   assign entry_count   = cnt_ff;
   assign status        = status_ff;

endmodule

[rtl/last_plugged_input_selector.sv]
// top level of the last-plugged input selector
// depends on lpis_pkg, lpis_req_if, lpis_rsp_if, lpis_ctrl, lpis_dp
//
// Usage:
//   req_chan carries plug (cmd 0) and unplug (cmd 1) events for a port number.
//   rsp_chan returns one result per event: the most recently plugged port still
//   in the list (or the default port when the list is empty), the entry count
//   after the event and a status code (ok, full, empty, not found).
//   csr_wr_en/csr_wr_data write the default port; write it only while idle.
// Timing:
//   an event is taken in the idle state and executed in the execute state by the
//   parallel compare-and-shift cells, whose result is registered once the output
//   register is free. A new event is taken only after the last one's result is
//   registered; the controller state machine (idle, execute) sets this.
// Reset:
//   the list empties, the count clears, the default port returns to 1 and no
//   result is pending.
// Stall:
//   while a result waits on rsp_chan the next event is still taken; it is held
//   in execute until the output register frees, and req_chan stays not ready.
module last_plugged_input_selector #(
   parameter int NUM_PORTS = lpis_pkg::DEF_NUM_PORTS
) (
   input  logic                        clock,
   input  logic                        reset,
   lpis_req_if.sink                    req_chan,
   lpis_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [lpis_pkg::PORT_W-1:0] csr_wr_data
);
   import lpis_pkg::*;

   dp_ctrl_type dp_ctrl;

   lpis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_ctrl   (dp_ctrl)
   );

   lpis_dp #(
      .NUM_PORTS (NUM_PORTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_ctrl       (dp_ctrl),
      .in_cmd        (req_chan.cmd),
      .in_port       (req_chan.port),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .selected_port (rsp_chan.selected_port),
      .entry_count   (rsp_chan.entry_count),
      .status        (rsp_chan.status)
   );

endmodule

[rtl/lpis_checker.sv]
// port-level checks of the last-plugged input selector, bound to the top level
// depends on lpis_pkg and last_plugged_input_selector_macros.svh
`include "last_plugged_input_selector_macros.svh"

module lpis_checker #(
   parameter int NUM_PORTS = lpis_pkg::DEF_NUM_PORTS
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [lpis_pkg::CNT_OUT_W-1:0] entry_count,
   input logic [1:0]                     status
);
   import lpis_pkg::*;

   localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(NUM_PORTS);

   logic                   rsp_stall;
   logic                   rsp_empty;
   logic                   rsp_full;
   logic                   req_xfer;
   logic [CNT_OUT_W+1:0]   rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_empty = rsp_valid && (status == ST_EMPTY);
   assign rsp_full  = rsp_valid && (status == ST_FULL);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_word  = {status, entry_count};

   // a pending result holds until the transfer
   `LPIS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "rsp changed in stall")

   // an empty-list result always reports no entries
   `LPIS_ASSERT_NOW(a_empty_cnt, rsp_empty, entry_count == '0, "empty with nonzero count")

   // a full-list result reports the full count
   `LPIS_ASSERT_NOW(a_full_cnt, rsp_full, entry_count == FULL_CNT, "full with wrong count")

   // one event in flight: no new transfer right after one was taken
   `LPIS_ASSERT_NEXT(a_one_busy, req_xfer, !req_ready, "event taken while busy")

endmodule

bind last_plugged_input_selector lpis_checker #(
   .NUM_PORTS (NUM_PORTS)
) u_lpis_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .entry_count (rsp_chan.entry_count),
   .status      (rsp_chan.status)
);

[dv/last_plugged_input_selector_test.sv]
// self-checking testbench of the last-plugged input selector: directed table, then random
// plug and unplug traffic checked against a predictor of the plugged-port list
// depends on lpis_pkg, lpis_req_if, lpis_rsp_if and last_plugged_input_selector
module last_plugged_input_selector_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lpis_pkg::*;

   localparam int NUM_PORTS   = DEF_NUM_PORTS;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 80;
   localparam int NUM_ROWS    = 22;

   typedef struct packed {
      logic [PORT_W-1:0]    sel;
      logic [CNT_OUT_W-1:0] count;
      status_type           status;
   } selection_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [PORT_W-1:0]    port;
      logic                 typed;
      logic [PORT_W-1:0]    w_sel;
      logic [CNT_OUT_W-1:0] w_cnt;
      status_type           w_st;
   } event_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [PORT_W-1:0]   csr_wr_data;

   lpis_req_if req_chan();
   lpis_rsp_if rsp_chan();

   last_plugged_input_selector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: plugged ports, oldest first
   logic [PORT_W-1:0] plug_list [NUM_PORTS];
   int                plug_count;
   logic [PORT_W-1:0] default_sel;
   int                fill_goal;

   selection_type     pending_selections [$];
   selection_type     front_sel;
   event_row_type     directed_rows [NUM_ROWS];

   int send_idle_pct;
   int recv_idle_pct;
   logic hold_rsp;
   int cycle_count;
   int mismatches;
   int plug_events;
   int unplug_events;
   int default_writes;
   int status_seen [4];

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
   endtask

   task automatic apply_event(input cmd_type c, input logic [PORT_W-1:0] p,
                              output selection_type res);
      int hit;
      status_type st;
      st = ST_OK;
      hit = -1;
      if (c == CMD_PLUG) begin
         if (plug_count >= NUM_PORTS) begin
            st = ST_FULL;
         end else begin
            plug_list[plug_count] = p;
            plug_count++;
         end
      end else if (plug_count == 0) begin
         st = ST_EMPTY;
      end else begin
         for (int i = 0; i < plug_count; i++)
            if (hit < 0 && plug_list[i] == p) hit = i;
         if (hit < 0) begin
            st = ST_NOT_FOUND;
         end else begin
            // close the gap and clear the vacated slot
            for (int i = hit; i < plug_count - 1; i++)
               plug_list[i] = plug_list[i+1];
            plug_count--;
            plug_list[plug_count] = '0;
         end
      end
      res.sel    = (plug_count > 0) ? plug_list[plug_count-1] : default_sel;
      res.count  = CNT_OUT_W'(plug_count);
      res.status = st;
   endtask

   task automatic send_event(input cmd_type c, input logic [PORT_W-1:0] p,
                             input logic typed, input selection_type typed_want);
      selection_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.cmd   = c;
      req_chan.port  = p;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_event(c, p, predicted);
      pending_selections.push_back(typed ? typed_want : predicted);
      if (c == CMD_PLUG) plug_events++;
      else unplug_events++;
      @(negedge clock);
   endtask

   // mostly sensible traffic steered toward a drifting fill level, with some noise
   task automatic pick_event(output cmd_type c, output logic [PORT_W-1:0] p);
      logic do_plug;
      if ($urandom_range(11) == 0) fill_goal = $urandom_range(NUM_PORTS);
      if (plug_count < fill_goal) do_plug = 1'b1;
      else if (plug_count > fill_goal) do_plug = 1'b0;
      else do_plug = 1'($urandom_range(1));
      if ($urandom_range(99) < 10) do_plug = !do_plug;
      if (do_plug) begin
         c = CMD_PLUG;
         if ($urandom_range(99) < 85) p = PORT_W'($urandom_range(1, 8));
         else p = PORT_W'($urandom_range(15));
      end else begin
         c = CMD_UNPLUG;
         if (plug_count > 0 && $urandom_range(99) < 85)
            p = plug_list[$urandom_range(plug_count - 1)];
         else
            p = PORT_W'($urandom_range(15));
      end
   endtask

   task automatic run_random(input int n);
      cmd_type c;
      logic [PORT_W-1:0] p;
      for (int k = 0; k < n; k++) begin
         pick_event(c, p);
         send_event(c, p, 1'b0, '0);
      end
   endtask

   // only while idle: drain, let the block settle, then write
   task automatic write_default(input logic [PORT_W-1:0] val);
      req_chan.valid = 1'b0;
      while (pending_selections.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      default_sel = val;
      default_writes++;
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_chan.ready = 1'b0;
         else rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_selections.size() == 0) begin
            report_mismatch("transfer with nothing pending, port",
                            int'(rsp_chan.selected_port), 0);
         end else begin
            front_sel = pending_selections.pop_front();
            status_seen[front_sel.status]++;
            if (rsp_chan.selected_port !== front_sel.sel)
               report_mismatch("selected_port", int'(rsp_chan.selected_port),
                               int'(front_sel.sel));
            if (rsp_chan.entry_count !== front_sel.count)
               report_mismatch("entry_count", int'(rsp_chan.entry_count),
                               int'(front_sel.count));
            if (rsp_chan.status !== front_sel.status)
               report_mismatch("status", int'(rsp_chan.status), int'(front_sel.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_selections.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd   = CMD_PLUG;
      req_chan.port  = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      hold_rsp       = 1'b0;
      send_idle_pct  = 36;
      recv_idle_pct  = 80;
      cycle_count    = 0;
      mismatches     = 0;
      plug_events    = 0;
      unplug_events  = 0;
      default_writes = 0;
      fill_goal      = 4;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      for (int i = 0; i < NUM_PORTS; i++) plug_list[i] = '0;
      plug_count  = 0;
      default_sel = DEFAULT_PORT_RST;

      directed_rows = '{
         '{CMD_UNPLUG, 4'd5,  1'b1, 4'd1,  4'd0, ST_EMPTY},
         '{CMD_PLUG,   4'd0,  1'b1, 4'd0,  4'd1, ST_OK},
         '{CMD_UNPLUG, 4'd0,  1'b1, 4'd1,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd15, 1'b1, 4'd15, 4'd1, ST_OK},
         '{CMD_PLUG,   4'd8,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd1,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd8,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd3,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd15, 1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd2,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd7,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd4,  1'b1, 4'd7,  4'd8, ST_FULL},
         '{CMD_UNPLUG, 4'd9,  1'b1, 4'd7,  4'd8, ST_NOT_FOUND},
         '{CMD_UNPLUG, 4'd8,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_UNPLUG, 4'd7,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_UNPLUG, 4'd15, 1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_UNPLUG, 4'd2,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_UNPLUG, 4'd1,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_UNPLUG, 4'd3,  1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_UNPLUG, 4'd15, 1'b0, 4'd0,  4'd0, ST_OK},
         '{CMD_UNPLUG, 4'd8,  1'b1, 4'd1,  4'd0, ST_OK},
         '{CMD_PLUG,   4'd10, 1'b0, 4'd0,  4'd0, ST_OK}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r])
         send_event(directed_rows[r].cmd, directed_rows[r].port, directed_rows[r].typed,
                    '{directed_rows[r].w_sel, directed_rows[r].w_cnt, directed_rows[r].w_st});

      write_default(4'd8);
      run_random(500);

      write_default(4'd15);
      send_idle_pct = 80;
      recv_idle_pct = 36;
      run_random(500);

      // receiver stalls long enough for the block to back up into the request side
      write_default(4'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            @(posedge clock);
            hold_rsp = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         run_random(20);
      join

      write_default(4'd1);
      run_random(390);
      write_default(PORT_W'($urandom_range(15)));
      run_random(390);

      req_chan.valid = 1'b0;
      while (pending_selections.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d events sent (%0d plug, %0d unplug), %0d default port writes",
               plug_events + unplug_events, plug_events, unplug_events, default_writes);
      $display("status mix: ok %0d, full %0d, empty %0d, not found %0d, mismatches %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_NOT_FOUND], mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
